/* design/bpso_pkg.sv */
// Shared types and constants for the binary PSO bit update block.
// Holds op codes, field widths and the sigmoid ROM built at elaboration.
// No dependencies.
package bpso_pkg;

	localparam int NUM_BITS = 64;
	localparam int IDX_W    = $clog2(NUM_BITS);
	localparam int GAIN_W   = 15;
	localparam int RAND_W   = 16;
	localparam int VEL_W    = 16;
	localparam int SUM_W    = VEL_W + 2;

	// register index on the config channel
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_VMAX  = 2'd2;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_BEST   = 2'd1,
		OP_INIT   = 2'd2
	} op_t;

	// one entry of the per-bit state memory
	typedef struct packed {
		logic             cur;
		logic             best;
		logic [VEL_W-1:0] vel;
	} ent_t;

	typedef logic [255:0][15:0] sig_rom_t;

	localparam logic [127:0] EXP_STEP_Q32 = 128'd4034748382;

	// 1/(1+exp(-x)) in Q0.16, x = signed high byte of velocity / 16.
	// exp(-k/16) in Q32 by repeated rounded multiply; long division by shift/subtract.
	function automatic sig_rom_t build_sigmoid();
		logic [63:0]  pos [129];
		logic [127:0] e;
		logic [63:0]  d;
		logic [63:0]  num;
		logic [63:0]  q;
		logic [64:0]  rem;
		sig_rom_t     rom;
		int           k;
		int           b;
		e = 128'h1 << 32;
		for (k = 0; k <= 128; k++) begin
			d   = 64'h1_0000_0000 + e[63:0];
			num = (64'h1 << 48) + (d >> 1);
			q   = '0;
			rem = '0;
			for (b = 63; b >= 0; b--) begin
				rem = {rem[63:0], num[b]};
				if (rem >= {1'b0, d}) begin
					rem  = rem - {1'b0, d};
					q[b] = 1'b1;
				end
			end
			pos[k] = q;
			e = (e * EXP_STEP_Q32 + (128'h1 << 31)) >> 32;
		end
		for (k = 0; k < 256; k++) begin
			if (k < 128)
				rom[k] = (pos[k] > 64'd65535) ? 16'hFFFF : pos[k][15:0];
			else
				rom[k] = 16'(64'd65536 - pos[256 - k]);
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sigmoid();

endpackage

/* design/binary_pso_bit_update.sv */
// Binary PSO bit update: per-bit current/best bit and Q4.12 velocity.
// Depends on bpso_pkg (op codes, state entry type, sigmoid ROM).
//
// channel   dir  handshake                     contents
// s_axis    in   s_axis_tvalid/s_axis_tready   one op word per bit update
// m_axis    out  m_axis_tvalid/m_axis_tready   bit state after the op
// cfg       in   cfg_valid/cfg_ready           gain and velocity limit writes
//
// One word per cycle while the result is not held; the result register loads when the word leaves stage 1.
// The state memory is read at the accept edge and written when the word leaves stage 1;
// the last write is forwarded so a same-index word right behind it sees it.
// Reset clears per-entry valid bits at once; unwritten entries read as zero.
// A held result stalls the update stage, which then stops taking input.
module binary_pso_bit_update
	import bpso_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[1:0], bit_index[7:2], global_best_bit[8], rand_local[24:9],
	// rand_global[40:25], rand_draw[56:41], init_bit[57], zero pad [63:58]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// current_bit[0], best_bit[1], velocity[17:2], zero pad [23:18]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	logic [GAIN_W-1:0] alpha_q, beta_q, vmax_q;

	// input unpack
	logic [1:0]        in_op;
	logic [IDX_W-1:0]  in_idx;
	logic              in_gbest;
	logic [RAND_W-1:0] in_r1, in_r2, in_r3;
	logic              in_init;
	logic              in_acc;

	// stage 1
	logic                    s1_vld_q;
	logic [1:0]              op_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    gbest_s1;
	logic [GAIN_W-1:0]       c1_s1, c2_s1;
	logic [RAND_W-1:0]       r3_s1;
	logic                    init_s1;
	ent_t                    rd_s1;
	logic                    rd_vld_s1;
	logic                    s1_adv;

	// state memory, valid bits, forward register
	ent_t                    mem_q [NUM_BITS];
	logic [NUM_BITS-1:0]     ent_vld_q;
	logic                    fwd_vld_q;
	logic [IDX_W-1:0]        fwd_idx_q;
	ent_t                    fwd_q;

	ent_t                    old_ent, new_ent;
	logic signed [SUM_W-1:0] v_old, d1, d2, v_sum, lim, v_clamp;
	logic [7:0]              sig_idx;

	logic                    out_vld_q;
	ent_t                    out_q;

	assign in_op    = s_axis_tdata[1:0];
	assign in_idx   = s_axis_tdata[7:2];
	assign in_gbest = s_axis_tdata[8];
	assign in_r1    = s_axis_tdata[24:9];
	assign in_r2    = s_axis_tdata[40:25];
	assign in_r3    = s_axis_tdata[56:41];
	assign in_init  = s_axis_tdata[57];

	assign cfg_ready     = 1'b1;
	assign s1_adv        = s1_vld_q && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !s1_vld_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= GAIN_W'(8192);
			beta_q  <= GAIN_W'(8192);
			vmax_q  <= GAIN_W'(16384);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA:  beta_q  <= cfg_data;
				REG_VMAX:  vmax_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 payload; gain products are taken off the input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= in_op;
			idx_s1   <= in_idx;
			gbest_s1 <= in_gbest;
			c1_s1    <= GAIN_W'((32'(alpha_q) * 32'(in_r1)) >> 16);
			c2_s1    <= GAIN_W'((32'(beta_q) * 32'(in_r2)) >> 16);
			r3_s1    <= in_r3;
			init_s1  <= in_init;
			rd_s1    <= mem_q[in_idx];
		end
		if (s1_adv)
			mem_q[idx_s1] <= new_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
			fwd_idx_q <= '0;
			fwd_q     <= '0;
		end else begin
			if (s_axis_tready)
				s1_vld_q <= s_axis_tvalid;
			if (in_acc)
				rd_vld_s1 <= ent_vld_q[in_idx];
			if (s1_adv) begin
				ent_vld_q[idx_s1] <= 1'b1;
				fwd_vld_q         <= 1'b1;
				fwd_idx_q         <= idx_s1;
				fwd_q             <= new_ent;
			end
		end
	end

	// entry as of now: latest write wins over the memory read
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == idx_s1)
			old_ent = fwd_q;
		else if (rd_vld_s1)
			old_ent = rd_s1;
		else
			old_ent = '0;
	end

	always_comb begin
		v_old = SUM_W'(signed'(old_ent.vel));
		lim   = signed'(SUM_W'(vmax_q));
		priority if (old_ent.best && !old_ent.cur)
			d1 = signed'(SUM_W'(c1_s1));
		else if (!old_ent.best && old_ent.cur)
			d1 = -signed'(SUM_W'(c1_s1));
		else
			d1 = '0;
		priority if (gbest_s1 && !old_ent.cur)
			d2 = signed'(SUM_W'(c2_s1));
		else if (!gbest_s1 && old_ent.cur)
			d2 = -signed'(SUM_W'(c2_s1));
		else
			d2 = '0;
		v_sum = v_old + d1 + d2;
		priority if (v_sum > lim)
			v_clamp = lim;
		else if (v_sum < -lim)
			v_clamp = -lim;
		else
			v_clamp = v_sum;
		sig_idx = v_clamp[VEL_W-1:VEL_W-8];

		new_ent = old_ent;
		unique case (op_s1)
			OP_UPDATE: begin
				new_ent.vel = v_clamp[VEL_W-1:0];
				new_ent.cur = (r3_s1 < SIG_ROM[sig_idx]);
			end
			OP_BEST: new_ent.best = old_ent.cur;
			OP_INIT: begin
				new_ent.cur  = init_s1;
				new_ent.best = init_s1;
				new_ent.vel  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (!out_vld_q || m_axis_tready)
			out_vld_q <= s1_adv;
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			out_q <= new_ent;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, out_q.vel, out_q.best, out_q.cur};

`ifndef SYNTHESIS
	a_vel_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1 == OP_UPDATE |-> v_clamp <= lim && v_clamp >= -lim)
		else $error("updated velocity outside limit");

	a_init_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1 == OP_INIT |=> out_q.vel == '0 && out_q.cur == out_q.best)
		else $error("init word did not clear velocity");

	a_entry_marked: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> ent_vld_q[fwd_idx_q] && fwd_idx_q == $past(idx_s1))
		else $error("written entry not marked valid");
`endif

endmodule

/* test/tb_binary_pso_bit_update.sv */
`timescale 1ns / 100ps
// Testbench for binary_pso_bit_update: random and directed op words in, bit state out.
// Depends on bpso_pkg and the block; keeps its own per-bit predictor and sigmoid table.
module tb_binary_pso_bit_update;
	import bpso_pkg::*;

	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam int         MAX_WAIT     = 13;
	localparam int         RUN_LIMIT_NS = 2_000_000;

	typedef struct {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic              gbest;
		logic [RAND_W-1:0] r_local;
		logic [RAND_W-1:0] r_global;
		logic [RAND_W-1:0] r_draw;
		logic              init_bit;
		int                gap;
	} op_word_t;

	typedef struct {
		logic             cur;
		logic             best;
		logic [VEL_W-1:0] vel;
	} bit_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// op[1:0], bit_index[7:2], global_best_bit[8], rand_local[24:9],
	// rand_global[40:25], rand_draw[56:41], init_bit[57], zero pad [63:58]
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// current_bit[0], best_bit[1], velocity[17:2], zero pad [23:18]
	logic [23:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	binary_pso_bit_update dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	op_word_t   word_backlog [$];
	bit_state_t bit_state_due [$];
	int         mismatches = 0;

	// predictor state
	logic [15:0]       logistic_rom [256];
	logic              cur_q  [NUM_BITS];
	logic              best_q [NUM_BITS];
	logic [VEL_W-1:0]  vel_q  [NUM_BITS];
	logic [GAIN_W-1:0] gain_local  = 15'd8192;
	logic [GAIN_W-1:0] gain_global = 15'd8192;
	logic [GAIN_W-1:0] vel_limit   = 15'd16384;

	int feed_idle = 0;
	int sink_hold = 0;
	int sink_taken = 0;
	bit sink_burst = 1'b0;

	task automatic note_mismatch(input string msg);
		if (mismatches < 200)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// logistic in Q0.16; exp(-k/16) kept in Q32 by repeated rounded multiply
	function automatic void build_logistic_rom();
		logic [127:0] e_q32;
		logic [63:0]  den;
		logic [63:0]  up_prob [129];
		int           k;
		e_q32 = 128'h1 << 32;
		for (k = 0; k <= 128; k++) begin
			den = 64'h1_0000_0000 + e_q32[63:0];
			up_prob[k] = ((64'h1 << 48) + den / 2) / den;
			e_q32 = (e_q32 * 128'd4034748382 + (128'h1 << 31)) >> 32;
		end
		for (k = 0; k < 256; k++) begin
			if (k < 128)
				logistic_rom[k] = (up_prob[k] > 64'd65535) ? 16'hFFFF : up_prob[k][15:0];
			else
				logistic_rom[k] = 16'(64'd65536 - up_prob[256 - k]);
		end
	endfunction

	function automatic bit_state_t advance_particle_bit(input op_word_t w);
		bit_state_t       s;
		int               pull_local;
		int               pull_global;
		int               v;
		int               lim;
		logic [VEL_W-1:0] v16;
		if (w.op == OP_UPDATE) begin
			pull_local  = (int'(gain_local) * int'(w.r_local)) >>> 16;
			pull_global = (int'(gain_global) * int'(w.r_global)) >>> 16;
			v = int'($signed(vel_q[w.idx]))
				+ pull_local * (int'(best_q[w.idx]) - int'(cur_q[w.idx]))
				+ pull_global * (int'(w.gbest) - int'(cur_q[w.idx]));
			lim = int'(vel_limit);
			if (v > lim)
				v = lim;
			if (v < -lim)
				v = -lim;
			v16 = v[VEL_W-1:0];
			vel_q[w.idx] = v16;
			// high byte of the velocity picks the table entry
			cur_q[w.idx] = (w.r_draw < logistic_rom[v16[15:8]]);
		end else if (w.op == OP_BEST) begin
			best_q[w.idx] = cur_q[w.idx];
		end else if (w.op == OP_INIT) begin
			cur_q[w.idx]  = w.init_bit;
			best_q[w.idx] = w.init_bit;
			vel_q[w.idx]  = '0;
		end
		s.cur  = cur_q[w.idx];
		s.best = best_q[w.idx];
		s.vel  = vel_q[w.idx];
		return s;
	endfunction

	// feed side: head of the backlog goes out after its own idle count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			feed_idle = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				void'(word_backlog.pop_front());
			if (!s_axis_tvalid || s_axis_tready) begin
				if (word_backlog.size() != 0 && feed_idle >= word_backlog[0].gap) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {6'b0, word_backlog[0].init_bit, word_backlog[0].r_draw,
						word_backlog[0].r_global, word_backlog[0].r_local,
						word_backlog[0].gbest, word_backlog[0].idx, word_backlog[0].op};
					feed_idle = 0;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (word_backlog.size() != 0)
						feed_idle++;
				end
			end
		end
	end

	// sink side: stall drawn after every taken result, with bursts of no stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				sink_taken++;
				if (sink_taken % 48 == 0)
					sink_burst = ($urandom_range(0, 3) == 0);
				sink_hold = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch
		op_word_t   w;
		bit_state_t want;
		bit_state_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALPHA: gain_local  = cfg_data;
					REG_BETA:  gain_global = cfg_data;
					REG_VMAX:  vel_limit   = cfg_data;
					default: ;
				endcase
			end
			// older result is checked before the new word is predicted
			if (m_axis_tvalid && m_axis_tready) begin
				got.cur  = m_axis_tdata[0];
				got.best = m_axis_tdata[1];
				got.vel  = m_axis_tdata[17:2];
				if (bit_state_due.size() == 0) begin
					note_mismatch($sformatf("result with none due: cur=%0b best=%0b vel=%0d",
						got.cur, got.best, $signed(got.vel)));
				end else begin
					want = bit_state_due.pop_front();
					if (got.cur !== want.cur || got.best !== want.best || got.vel !== want.vel)
						note_mismatch($sformatf(
							"cur %0b/%0b best %0b/%0b vel %0d/%0d (got/want)",
							got.cur, want.cur, got.best, want.best,
							$signed(got.vel), $signed(want.vel)));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				w.op       = s_axis_tdata[1:0];
				w.idx      = s_axis_tdata[7:2];
				w.gbest    = s_axis_tdata[8];
				w.r_local  = s_axis_tdata[24:9];
				w.r_global = s_axis_tdata[40:25];
				w.r_draw   = s_axis_tdata[56:41];
				w.init_bit = s_axis_tdata[57];
				w.gap      = 0;
				bit_state_due.insert(bit_state_due.size(), advance_particle_bit(w));
			end
		end
	end

	task automatic push_word(input logic [1:0] op, input logic [IDX_W-1:0] idx,
		input logic gbest, input logic [15:0] r1, input logic [15:0] r2,
		input logic [15:0] r3, input logic ib, input int gap);
		op_word_t w;
		w.op       = op;
		w.idx      = idx;
		w.gbest    = gbest;
		w.r_local  = r1;
		w.r_global = r2;
		w.r_draw   = r3;
		w.init_bit = ib;
		w.gap      = gap;
		word_backlog.insert(word_backlog.size(), w);
	endtask

	task automatic random_words(input int count);
		int         n;
		int         pick;
		bit         burst;
		bit         narrow;
		logic [1:0] op;
		for (n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				burst  = ($urandom_range(0, 3) == 0);
				narrow = ($urandom_range(0, 2) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 66)
				op = OP_UPDATE;
			else if (pick < 80)
				op = OP_BEST;
			else if (pick < 95)
				op = OP_INIT;
			else
				op = OP_SPARE;
			// narrow runs hammer a few indexes so same-index words land back to back
			push_word(op,
				narrow ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, NUM_BITS - 1)),
				1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom),
				1'($urandom_range(0, 1)), burst ? 0 : $urandom_range(0, MAX_WAIT));
		end
	endtask

	// block until every word is taken and every result is back
	task automatic settle();
		while (word_backlog.size() != 0 || bit_state_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] which, input logic [14:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int k;
		int phase;
		build_logistic_rom();
		for (k = 0; k < NUM_BITS; k++) begin
			cur_q[k]  = 1'b0;
			best_q[k] = 1'b0;
			vel_q[k]  = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset gains
		push_word(OP_INIT,   6'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
		push_word(OP_INIT,   6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
		push_word(OP_UPDATE, 6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
		push_word(OP_UPDATE, 6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
		push_word(OP_UPDATE, 6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 3);
		push_word(OP_BEST,   6'd63, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd0,  1'b0, 16'h0000, 16'hFFFF, 16'h8000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd0,  1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd0,  1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 0);
		push_word(OP_SPARE,  6'd0,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
		push_word(OP_SPARE,  6'd40, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5);
		push_word(OP_INIT,   6'd0,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
		push_word(OP_BEST,   6'd1,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0);
		// zero velocity picks table entry 0, the sigmoid midpoint of one half
		push_word(OP_UPDATE, 6'd2,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd2,  1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 0);
		push_word(OP_UPDATE, 6'd2,  1'b0, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 0);
		for (k = 0; k < 4; k++)
			push_word(OP_UPDATE, 6'd9, 1'b1, 16'hC000, 16'hFFFF, 16'h4000, 1'b0, 0);
		push_word(OP_BEST,   6'd9,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
		push_word(OP_UPDATE, 6'd9,  1'b0, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, 0);
		settle();

		random_words(250);
		settle();

		set_register(REG_ALPHA, 15'h7FFF);
		set_register(REG_BETA,  15'h7FFF);
		set_register(REG_VMAX,  15'h7FFF);
		random_words(140);
		settle();
		random_words(140);
		settle();

		set_register(REG_ALPHA, 15'd0);
		set_register(REG_BETA,  15'd0);
		set_register(REG_VMAX,  15'd1);
		random_words(200);
		settle();

		// a zero limit pins every updated velocity at zero
		set_register(REG_VMAX,  15'd0);
		set_register(REG_ALPHA, 15'd20000);
		set_register(REG_BETA,  15'd3000);
		random_words(200);
		settle();

		set_register(REG_ALPHA, 15'd4096);
		set_register(REG_BETA,  15'd12000);
		set_register(REG_VMAX,  15'd3000);
		random_words(200);

		for (phase = 0; phase < 3; phase++) begin
			settle();
			set_register(REG_ALPHA, 15'($urandom_range(0, 32767)));
			set_register(REG_BETA,  15'($urandom_range(0, 32767)));
			set_register(REG_VMAX,  15'($urandom_range(0, 32767)));
			random_words(175);
		end

		while (word_backlog.size() != 0)
			@(negedge clk);
		for (k = 0; k < 2000 && bit_state_due.size() != 0; k++)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (bit_state_due.size() != 0)
			note_mismatch($sformatf("%0d results never came", bit_state_due.size()));
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
